[hdl/tmse_pkg.sv]
// shared types, constants and codes of the turing machine step engine
`timescale 1ns / 1ps

package tmse_pkg;

    // default sizes
    localparam int TMSE_MAX_STATES  = 16;
    localparam int TMSE_MAX_SYMBOLS = 16;
    localparam int TMSE_TAPE_LEN    = 256;

    // fixed field widths
    localparam int ACT_W     = 3;
    localparam int STATE_W   = 4;
    localparam int SYM_W     = 4;
    localparam int DIR_W     = 2;
    localparam int CELL_W    = 8;
    localparam int HEAD_O_W  = 8;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    // reset values of the start registers
    localparam logic [STATE_W-1:0] START_STATE_RST = '0;
    localparam logic [CFG_W-1:0]   START_HEAD_RST  = 8'd128;

    typedef enum logic [ACT_W-1:0] {
        ACT_WR_RULE = 3'd0,
        ACT_WR_CELL = 3'd1,
        ACT_START   = 3'd2,
        ACT_STEP    = 3'd3,
        ACT_RD_CELL = 3'd4
    } tmse_action_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_STAY = 2'd0,
        DIR_LEFT = 2'd1
    } tmse_dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STATE = 1'b0,
        CFG_START_HEAD  = 1'b1
    } tmse_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_EXEC,
        ST_READ,
        ST_RESP
    } tmse_fsm_t;

    // one rule table entry, all zero is unset / stay
    typedef struct packed {
        logic [SYM_W-1:0]   sym;
        logic               sym_ok;
        logic [STATE_W-1:0] nxt;
        logic               nxt_ok;
        logic [DIR_W-1:0]   dir;
    } tmse_rule_t;

    // captured command fields
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [STATE_W-1:0] rule_state;
        logic [SYM_W-1:0]   rule_symbol;
        logic [SYM_W-1:0]   new_symbol;
        logic               keep_symbol;
        logic [STATE_W-1:0] new_state;
        logic               keep_state;
        logic [DIR_W-1:0]   direction;
        logic [CELL_W-1:0]  cell_index;
        logic [SYM_W-1:0]   cell_value;
    } tmse_cmd_t;

    // response fields
    typedef struct packed {
        logic [STATE_W-1:0]  current_state;
        logic [HEAD_O_W-1:0] head_position;
        logic [SYM_W-1:0]    head_symbol;
        logic                can_step;
        logic                off_tape;
        logic [SYM_W-1:0]    read_value;
    } tmse_rsp_t;

    // control from the sequencer to the tape ring
    typedef struct packed {
        logic             seek;
        logic             step_fwd;
        logic             step_bwd;
        logic             wr_en;
        logic [SYM_W-1:0] wr_data;
    } tmse_tape_ctl_t;

    // status from the tape ring
    typedef struct packed {
        logic             aligned;
        logic [SYM_W-1:0] sym;
    } tmse_tape_sts_t;

endpackage

[hdl/tmse_if.sv]
// command and response channel interfaces of the turing machine step engine
`timescale 1ns / 1ps

interface tmse_cmd_if
    import tmse_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [STATE_W-1:0] rule_state;
    logic [SYM_W-1:0]   rule_symbol;
    logic [SYM_W-1:0]   new_symbol;
    logic               keep_symbol;
    logic [STATE_W-1:0] new_state;
    logic               keep_state;
    logic [DIR_W-1:0]   direction;
    logic [CELL_W-1:0]  cell_index;
    logic [SYM_W-1:0]   cell_value;

    modport source (
        output valid, action, rule_state, rule_symbol, new_symbol, keep_symbol,
               new_state, keep_state, direction, cell_index, cell_value,
        input  ready
    );
    modport sink (
        input  valid, action, rule_state, rule_symbol, new_symbol, keep_symbol,
               new_state, keep_state, direction, cell_index, cell_value,
        output ready
    );
endinterface

interface tmse_rsp_if
    import tmse_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATE_W-1:0]  current_state;
    logic [HEAD_O_W-1:0] head_position;
    logic [SYM_W-1:0]    head_symbol;
    logic                can_step;
    logic                off_tape;
    logic [SYM_W-1:0]    read_value;

    modport source (
        output valid, current_state, head_position, head_symbol, can_step, off_tape,
               read_value,
        input  ready
    );
    modport sink (
        input  valid, current_state, head_position, head_symbol, can_step, off_tape,
               read_value,
        output ready
    );
endinterface

[hdl/tmse_cell.sv]
// one tape cell of the rotating tape ring
`timescale 1ns / 1ps

module tmse_cell
    import tmse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fwd,
    input  logic             bwd,
    input  logic             wr_en,
    input  logic [SYM_W-1:0] wr_data,
    input  logic [SYM_W-1:0] nxt_sym,
    input  logic [SYM_W-1:0] prv_sym,
    output logic [SYM_W-1:0] eff
);

    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;

    // rotation wins over a local write, the written value travels on via eff
    always_comb
    begin
        priority if (fwd)
        begin
            sym_next = nxt_sym;
        end
        else if (bwd)
        begin
            sym_next = prv_sym;
        end
        else if (wr_en)
        begin
            sym_next = wr_data;
        end
        else
        begin
            sym_next = sym_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg <= '0;
        end
        else
        begin
            sym_reg <= sym_next;
        end
    end

    assign eff = wr_en ? wr_data : sym_reg;

endmodule

[hdl/tmse_tape.sv]
// tape as a ring of cells that rotates so the addressed cell sits at position zero
`timescale 1ns / 1ps

module tmse_tape
    import tmse_pkg::*;
#(
    parameter int TAPE_LEN  = TMSE_TAPE_LEN,
    parameter int HW        = $clog2(TMSE_TAPE_LEN),
    parameter int HEAD_INIT = 128
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  tmse_tape_ctl_t ctl,
    input  logic [HW-1:0]  target,
    output logic [HW-1:0]  offset,
    output tmse_tape_sts_t sts
);

    localparam logic [HW-1:0] LAST = HW'(TAPE_LEN - 1);
    localparam logic [HW:0]   LEN_X = (HW+1)'(TAPE_LEN);
    localparam logic [HW:0]   HALF_X = (HW+1)'(TAPE_LEN / 2);

    logic [HW-1:0]    offset_reg;
    logic [HW-1:0]    offset_next;
    logic [HW:0]      fwd_gap;
    logic             aligned;
    logic             go_fwd;
    logic             rot_fwd;
    logic             rot_bwd;
    logic [SYM_W-1:0] eff [TAPE_LEN];

    assign aligned = (offset_reg == target);

    // forward distance around the ring, pick the shorter way
    always_comb
    begin
        if (target >= offset_reg)
        begin
            fwd_gap = {1'b0, target} - {1'b0, offset_reg};
        end
        else
        begin
            fwd_gap = {1'b0, target} + LEN_X - {1'b0, offset_reg};
        end
        go_fwd = (fwd_gap <= HALF_X);
    end

    assign rot_fwd = ctl.step_fwd || (ctl.seek && !aligned && go_fwd);
    assign rot_bwd = ctl.step_bwd || (ctl.seek && !aligned && !go_fwd);

    always_comb
    begin
        priority if (rot_fwd)
        begin
            offset_next = (offset_reg == LAST) ? '0 : offset_reg + 1'b1;
        end
        else if (rot_bwd)
        begin
            offset_next = (offset_reg == '0) ? LAST : offset_reg - 1'b1;
        end
        else
        begin
            offset_next = offset_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= HW'(HEAD_INIT);
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

    for (genvar k = 0; k < TAPE_LEN; k++)
    begin : g_ring
        tmse_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .fwd     (rot_fwd),
            .bwd     (rot_bwd),
            .wr_en   ((k == 0) && ctl.wr_en),
            .wr_data (ctl.wr_data),
            .nxt_sym (eff[(k + 1) % TAPE_LEN]),
            .prv_sym (eff[(k + TAPE_LEN - 1) % TAPE_LEN]),
            .eff     (eff[k])
        );
    end

    assign offset      = offset_reg;
    assign sts.aligned = aligned;
    assign sts.sym     = eff[0];

endmodule

[hdl/tmse_rules.sv]
// rule table memory with a clearing sweep after reset
`timescale 1ns / 1ps

module tmse_rules
    import tmse_pkg::*;
#(
    parameter int DEPTH = TMSE_MAX_STATES * TMSE_MAX_SYMBOLS,
    parameter int AW    = $clog2(TMSE_MAX_STATES * TMSE_MAX_SYMBOLS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  tmse_rule_t    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output tmse_rule_t    rd_data,
    output logic          busy
);

    tmse_rule_t    mem [DEPTH];
    tmse_rule_t    rd_data_reg;
    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

[hdl/turing_machine_step_engine.sv]
// top level of the turing machine step engine: sequencer, machine registers, ports
`timescale 1ns / 1ps

// Single-tape Turing machine. Each command transaction carries one action (write
// rule, write cell, start, step, read cell; other codes do nothing) and yields
// exactly one response transaction with the machine state, head position, symbol
// under the head, whether the machine can step, the sticky off-tape flag and, for
// read cell, the addressed symbol. The tape is a ring of TAPE_LEN cells that
// rotates one position per cycle so that the cell being worked on always sits at
// position zero; the rule table is a memory with one write port, one read port
// and a registered read. A step passes through execute, rule read and response,
// and a new command is taken in the response state once the response slot is
// free, so back-to-back steps follow without an idle state. Rule writes and
// unused codes pass through the same states. Start adds a seek to the new head.
// Write cell and read cell seek the addressed cell, execute, then seek back to
// the head, each rotation at most TAPE_LEN/2 positions. After reset the rule
// table is swept to unset over all MAX_STATES * MAX_SYMBOLS entries, during
// which no command is taken; configuration writes are taken at any time.

module turing_machine_step_engine
    import tmse_pkg::*;
#(
    parameter int MAX_STATES  = TMSE_MAX_STATES,
    parameter int MAX_SYMBOLS = TMSE_MAX_SYMBOLS,
    parameter int TAPE_LEN    = TMSE_TAPE_LEN
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    tmse_cmd_if.sink             cmd,
    tmse_rsp_if.source           rsp
);

    localparam int HW        = $clog2(TAPE_LEN);
    localparam int DEPTH     = MAX_STATES * MAX_SYMBOLS;
    localparam int AW        = $clog2(DEPTH);
    localparam int HEAD_INIT = (128 < TAPE_LEN) ? 128 : TAPE_LEN - 1;

    // sequencer and machine registers
    tmse_fsm_t          state_reg, state_next;
    logic               post_reg, post_next;     // action done, seek goes to head
    tmse_cmd_t          item_reg, item_next;
    logic [STATE_W-1:0] mach_reg, mach_next;
    logic [HW-1:0]      head_reg, head_next;
    logic               edge_reg, edge_next;
    logic [SYM_W-1:0]   rdv_reg, rdv_next;
    logic               rng_reg, rng_next;       // rule lookup index in range
    tmse_rule_t         rule_reg, rule_next;     // rule for current state and head symbol
    logic [STATE_W-1:0] sst_reg;
    logic [CFG_W-1:0]   shd_reg;

    // response slot
    logic      rsp_vld_reg, rsp_vld_next;
    tmse_rsp_t rsp_data_reg, rsp_data_next;

    // sub-block connections
    tmse_tape_ctl_t tape_ctl;
    tmse_tape_sts_t tape_sts;
    logic [HW-1:0]  tape_target;
    logic [HW-1:0]  tape_offset;
    logic           rule_we;
    logic [AW-1:0]  rule_waddr;
    tmse_rule_t     rule_wdata;
    logic           rule_re;
    logic [AW-1:0]  rule_raddr;
    tmse_rule_t     rule_rdata;
    logic           clr_busy;

    // handshake helpers
    tmse_cmd_t cmd_in;
    logic      accept;
    logic      slot_free;
    logic      cmd_to_seek;
    logic      item_cell_ok;
    logic      rule_idx_ok;
    logic      look_ok;

    assign cmd_in.action      = cmd.action;
    assign cmd_in.rule_state  = cmd.rule_state;
    assign cmd_in.rule_symbol = cmd.rule_symbol;
    assign cmd_in.new_symbol  = cmd.new_symbol;
    assign cmd_in.keep_symbol = cmd.keep_symbol;
    assign cmd_in.new_state   = cmd.new_state;
    assign cmd_in.keep_state  = cmd.keep_state;
    assign cmd_in.direction   = cmd.direction;
    assign cmd_in.cell_index  = cmd.cell_index;
    assign cmd_in.cell_value  = cmd.cell_value;

    assign slot_free = !rsp_vld_reg || rsp.ready;
    assign cmd.ready = !clr_busy
                     && ((state_reg == ST_IDLE) || ((state_reg == ST_RESP) && slot_free));
    assign accept    = cmd.valid && cmd.ready;

    // cell actions inside the tape rotate to the addressed cell first
    assign cmd_to_seek = ((cmd_in.action == ACT_WR_CELL) || (cmd_in.action == ACT_RD_CELL))
                       && (32'(cmd_in.cell_index) < TAPE_LEN);

    assign item_cell_ok = 32'(item_reg.cell_index) < TAPE_LEN;
    assign rule_idx_ok  = (32'(item_reg.rule_state) < MAX_STATES)
                        && (32'(item_reg.rule_symbol) < MAX_SYMBOLS);
    assign look_ok      = (32'(mach_reg) < MAX_STATES) && (32'(tape_sts.sym) < MAX_SYMBOLS);

    // next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cmd_to_seek ? ST_SEEK : ST_EXEC;
                end
            end
            ST_SEEK:
            begin
                if (tape_sts.aligned)
                begin
                    state_next = post_reg ? ST_READ : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // start and cell actions may leave the ring away from the head
                if ((item_reg.action == ACT_START) || (item_reg.action == ACT_WR_CELL)
                    || (item_reg.action == ACT_RD_CELL))
                begin
                    state_next = ST_SEEK;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    if (accept)
                    begin
                        state_next = cmd_to_seek ? ST_SEEK : ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and sub-block controls
    always_comb
    begin
        post_next     = post_reg;
        item_next     = item_reg;
        mach_next     = mach_reg;
        head_next     = head_reg;
        edge_next     = edge_reg;
        rdv_next      = rdv_reg;
        rng_next      = rng_reg;
        rule_next     = rule_reg;
        rsp_vld_next  = rsp_vld_reg && !rsp.ready;
        rsp_data_next = rsp_data_reg;

        tape_ctl   = '0;
        rule_we    = 1'b0;
        rule_waddr = AW'(32'(item_reg.rule_state) * MAX_SYMBOLS + 32'(item_reg.rule_symbol));
        rule_wdata.sym    = item_reg.new_symbol;
        rule_wdata.sym_ok = !item_reg.keep_symbol;
        rule_wdata.nxt    = item_reg.new_state;
        rule_wdata.nxt_ok = !item_reg.keep_state;
        rule_wdata.dir    = item_reg.direction;
        rule_re    = 1'b0;
        rule_raddr = AW'(32'(mach_reg) * MAX_SYMBOLS + 32'(tape_sts.sym));

        // seek to the addressed cell before the action, to the head after it
        tape_target = post_reg ? head_reg : HW'(item_reg.cell_index);

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SEEK:
            begin
                tape_ctl.seek = 1'b1;
            end
            ST_EXEC:
            begin
                post_next = 1'b1;
                unique case (item_reg.action)
                    ACT_WR_RULE:
                    begin
                        rule_we = rule_idx_ok;
                    end
                    ACT_WR_CELL:
                    begin
                        tape_ctl.wr_en   = item_cell_ok;
                        tape_ctl.wr_data = item_reg.cell_value;
                    end
                    ACT_START:
                    begin
                        mach_next = sst_reg;
                        head_next = (32'(shd_reg) < TAPE_LEN) ? HW'(shd_reg)
                                                               : HW'(TAPE_LEN - 1);
                        edge_next = 1'b0;
                    end
                    ACT_STEP:
                    begin
                        if (rule_reg.sym_ok && rule_reg.nxt_ok)
                        begin
                            // write and move in the same cycle, the written symbol rides the ring
                            tape_ctl.wr_en   = 1'b1;
                            tape_ctl.wr_data = rule_reg.sym;
                            mach_next        = rule_reg.nxt;
                            if (rule_reg.dir == DIR_LEFT)
                            begin
                                if (head_reg == '0)
                                begin
                                    edge_next = 1'b1;
                                end
                                else
                                begin
                                    head_next         = head_reg - 1'b1;
                                    tape_ctl.step_bwd = 1'b1;
                                end
                            end
                            else if (rule_reg.dir != DIR_STAY)
                            begin
                                if (head_reg == HW'(TAPE_LEN - 1))
                                begin
                                    edge_next = 1'b1;
                                end
                                else
                                begin
                                    head_next         = head_reg + 1'b1;
                                    tape_ctl.step_fwd = 1'b1;
                                end
                            end
                        end
                    end
                    ACT_RD_CELL:
                    begin
                        rdv_next = item_cell_ok ? tape_sts.sym : '0;
                    end
                    default:
                    begin
                        // unused action codes change nothing
                    end
                endcase
            end
            ST_READ:
            begin
                rule_re  = 1'b1;
                rng_next = look_ok;
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    rule_next                   = rng_reg ? rule_rdata : '0;
                    rsp_vld_next                = 1'b1;
                    rsp_data_next.current_state = mach_reg;
                    rsp_data_next.head_position = HEAD_O_W'(head_reg);
                    rsp_data_next.head_symbol   = tape_sts.sym;
                    rsp_data_next.can_step      = rng_reg && rule_rdata.sym_ok
                                                          && rule_rdata.nxt_ok;
                    rsp_data_next.off_tape      = edge_reg;
                    rsp_data_next.read_value    = rdv_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (accept)
        begin
            item_next = cmd_in;
            post_next = 1'b0;
            rdv_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            post_reg    <= 1'b0;
            mach_reg    <= '0;
            head_reg    <= HW'(HEAD_INIT);
            edge_reg    <= 1'b0;
            rule_reg    <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            post_reg    <= post_next;
            mach_reg    <= mach_next;
            head_reg    <= head_next;
            edge_reg    <= edge_next;
            rule_reg    <= rule_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        rdv_reg      <= rdv_next;
        rng_reg      <= rng_next;
        rsp_data_reg <= rsp_data_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sst_reg <= START_STATE_RST;
            shd_reg <= START_HEAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (tmse_cfg_t'(cfg_index))
                CFG_START_STATE: sst_reg <= cfg_wdata[STATE_W-1:0];
                CFG_START_HEAD:  shd_reg <= cfg_wdata;
                default:         shd_reg <= shd_reg;
            endcase
        end
    end

    tmse_tape #(
        .TAPE_LEN  (TAPE_LEN),
        .HW        (HW),
        .HEAD_INIT (HEAD_INIT)
    ) u_tape (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (tape_ctl),
        .target (tape_target),
        .offset (tape_offset),
        .sts    (tape_sts)
    );

    tmse_rules #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_rules (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rule_we),
        .wr_addr (rule_waddr),
        .wr_data (rule_wdata),
        .rd_en   (rule_re),
        .rd_addr (rule_raddr),
        .rd_data (rule_rdata),
        .busy    (clr_busy)
    );

    assign rsp.valid         = rsp_vld_reg;
    assign rsp.current_state = rsp_data_reg.current_state;
    assign rsp.head_position = rsp_data_reg.head_position;
    assign rsp.head_symbol   = rsp_data_reg.head_symbol;
    assign rsp.can_step      = rsp_data_reg.can_step;
    assign rsp.off_tape      = rsp_data_reg.off_tape;
    assign rsp.read_value    = rsp_data_reg.read_value;

    // the rule lookup always sees the ring parked on the head
    a_read_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (tape_offset == head_reg))
        else $error("rule lookup with tape ring away from head");

    // head never leaves the tape
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg) < TAPE_LEN)
        else $error("head outside tape");

    // no command taken during the rule table sweep
    a_no_cmd_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !cmd.ready)
        else $error("command ready while rule table is clearing");

endmodule
